// File: rtl/core/bbce_pkg.sv
// ----------------------------------------------------------------------------
// bbce_pkg
// Shared types and codes for the clamped-edge box blur.
// ----------------------------------------------------------------------------
package bbce_pkg;

  localparam int COLORS  = 3;
  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = COLORS * CHAN_W;

  // one stored pixel: red [7:0], green [15:8], blue [23:16]
  typedef logic [PIXEL_W-1:0] rgb_t;

  // input item kinds (tuser)
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

endpackage

// File: rtl/core/bbce_line_store.sv
// ----------------------------------------------------------------------------
// bbce_line_store
// Single-port-write, single-port-read pixel memory with registered read data.
// ----------------------------------------------------------------------------
module bbce_line_store #(
  parameter int DEPTH = 9216
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  bbce_pkg::rgb_t            wr_data,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output bbce_pkg::rgb_t            rd_data
);

  bbce_pkg::rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/bbce_divider.sv
// ----------------------------------------------------------------------------
// bbce_divider
// Shared restoring divider: three window sums by the window size, one
// quotient bit per cycle, colors in turn. Quotients fit in eight bits.
// ----------------------------------------------------------------------------
module bbce_divider #(
  parameter int NUM_W = 7,
  parameter int SUM_W = 15
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [NUM_W-1:0]                              n,
  input  logic [bbce_pkg::COLORS-1:0][SUM_W-1:0]        sums,
  output logic                                          done,
  output logic [bbce_pkg::COLORS-1:0][bbce_pkg::CHAN_W-1:0] quot
);

  localparam int QB  = bbce_pkg::CHAN_W;
  localparam int RMW = NUM_W + QB;
  localparam int CIW = $clog2(bbce_pkg::COLORS);
  localparam int BIW = $clog2(QB);

  logic           busy;
  logic [CIW-1:0] cidx;
  logic [BIW-1:0] bidx;
  logic [RMW-1:0] rem;
  logic [RMW-1:0] den;
  logic [QB-2:0]  qsh;
  logic           ge;

  assign ge = (rem >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cidx <= '0;
        bidx <= BIW'(QB - 1);
        rem  <= RMW'(sums[0]);
        den  <= RMW'(n) << (QB - 1);
      end else if (busy) begin
        rem  <= ge ? rem - den : rem;
        den  <= den >> 1;
        qsh  <= {qsh[QB-3:0], ge};
        bidx <= bidx - 1'b1;
        if (bidx == '0) begin
          quot[cidx] <= {qsh, ge};
          if (cidx == CIW'(bbce_pkg::COLORS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cidx <= cidx + 1'b1;
            bidx <= BIW'(QB - 1);
            rem  <= RMW'(sums[CIW'(cidx + 1'b1)]);
            den  <= RMW'(n) << (QB - 1);
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/box_blur_clamped_edges.sv
// ----------------------------------------------------------------------------
// box_blur_clamped_edges
// Streaming (2R+1)x(2R+1) box blur with clamp-to-edge window coordinates.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries pixels in raster order (tuser = 0) or flush ticks
//    (tuser = 1). Each transaction yields zero or one blurred pixel on the
//    master stream; tlast marks the last pixel of the frame.
//  - Flush ticks after the frame ends drain the remaining outputs, one each.
//  - Config channel writes width, height or radius while the block is idle
//    and its output register is empty; a config write wins over a pixel
//    offered in the same cycle. A write to one of these three restarts the
//    frame, the line store contents are kept.
//  - One transaction at a time. A transaction that emits steps the read base
//    up min(row,R) rows, makes one line store read per window element (81
//    reads at R=4), runs the shared bit-serial divider (8 quotient bits per
//    color) and passes check, drain and start steps around these. Without an
//    output it goes from the check step straight back to idle.
//  - Results sit in an output register; the next input is accepted while it
//    waits. A stalled receiver holds the block in its emit step.
//  - Reset (synchronous) restores the default registers and clears the frame
//    position. The line store needs no clearing pass.
// ----------------------------------------------------------------------------
module box_blur_clamped_edges #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // in_red[7:0], in_green[15:8], in_blue[23:16]
  input  logic        s_tuser,   // func
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_red, out_green, out_blue, out_column[33:24],
                                 // out_row[45:34], zero pad
  output logic        m_tlast,   // frame_last
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RWID  = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RDW   = $clog2(MAX_RADIUS + 1);
  localparam int KW    = $clog2(2 * MAX_RADIUS + 1);
  localparam int LW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int NMAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int NW    = $clog2(NMAX + 1);
  localparam int SW    = $clog2(NMAX * 255 + 1);
  localparam int VCW   = CW + 2;
  localparam int VRW   = RWID + 2;
  localparam int NC    = bbce_pkg::COLORS;
  localparam int CH    = bbce_pkg::CHAN_W;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CHECK   = 8'b0000_0010,
    S_ROWUP   = 8'b0000_0100,
    S_READ    = 8'b0000_1000,
    S_DRAIN   = 8'b0001_0000,
    S_DIVGO   = 8'b0010_0000,
    S_DIVWAIT = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_t;

  state_t state;

  // config registers and their clamped values
  logic [10:0]   width_r;
  logic [12:0]   height_r;
  logic [2:0]    radius_r;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [RDW-1:0] r_eff;

  always_comb begin
    if (width_r == '0)                 w_eff = WW'(1);
    else if (32'(width_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else                               w_eff = WW'(width_r);
    if (height_r == '0)                  h_eff = HW'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else                                 h_eff = HW'(height_r);
    if (32'(radius_r) > MAX_RADIUS) r_eff = RDW'(MAX_RADIUS);
    else                            r_eff = RDW'(radius_r);
  end

  // frame geometry, re-registered every cycle (multipliers off the item path)
  logic [LW-1:0]  total_r;
  logic [LW-1:0]  rw1_r;     // R*W + R + 1
  logic [NW-1:0]  n_r;       // (2R+1)^2
  logic [RDW:0]   r2p1;

  assign r2p1 = {r_eff, 1'b1};

  always_ff @(posedge clk) begin
    total_r <= LW'(w_eff) * LW'(h_eff);
    rw1_r   <= LW'(r_eff) * LW'(w_eff) + LW'(r_eff) + LW'(1);
    n_r     <= NW'(r2p1) * NW'(r2p1);
  end

  // position state
  logic [LW-1:0]   in_lin;     // pixels received this frame
  logic [AW-1:0]   wr_addr;    // in_lin mod DEPTH
  logic [CW-1:0]   out_col;
  logic [RWID-1:0] out_row;
  logic [LW-1:0]   out_lin;
  logic [AW-1:0]   orow_base;  // out_row*W mod DEPTH

  // window walk
  logic [AW-1:0]          base;
  logic [RWID-1:0]        cur_row;
  logic signed [VRW-1:0]  virt_row;
  logic signed [VCW-1:0]  virt_col;
  logic [KW-1:0]          dx;
  logic [KW-1:0]          dy;
  logic [RDW-1:0]         up_cnt;
  logic                   rd_vld;
  logic [NC-1:0][SW-1:0]  sums;

  logic                   s_acc;
  logic                   cfg_acc;
  logic                   store;
  logic                   out_free;
  logic                   is_last;
  logic [LW:0]            need_raw;
  logic [LW-1:0]          need;
  logic                   emit_ok;
  logic [RDW-1:0]         up_v;
  logic [CW-1:0]          col_sel;
  logic [AW:0]            addr_sum;
  logic [AW-1:0]          rd_addr;
  logic [AW:0]            base_dn;
  logic [AW:0]            base_up;
  logic [AW:0]            orow_up;
  logic [KW-1:0]          two_r;
  logic                   rd_en;
  bbce_pkg::rgb_t         rd_data;
  logic                   div_done;
  logic [NC-1:0][CH-1:0]  quot;
  logic [31:0]            col_w;
  logic [31:0]            row_w;

  // config has priority over a pixel in the same idle cycle
  assign s_tready  = (state == S_IDLE) && !cfg_valid && !rst;
  assign cfg_ready = (state == S_IDLE) && !m_tvalid && !rst;
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign store     = (s_tuser == bbce_pkg::FUNC_PIXEL) && (in_lin < total_r);
  assign out_free  = !m_tvalid || m_tready;
  assign is_last   = (out_lin == total_r - LW'(1));
  assign two_r     = KW'({r_eff, 1'b0});

  // output pixel is ready once min(p + R*W + R + 1, W*H) pixels are in
  assign need_raw = {1'b0, out_lin} + {1'b0, rw1_r};
  assign need     = (need_raw > {1'b0, total_r}) ? total_r : need_raw[LW-1:0];
  assign emit_ok  = (in_lin >= need);

  // rows above the output row that the window reaches before clamping
  assign up_v = (RWID'(r_eff) > out_row) ? RDW'(out_row) : r_eff;

  // clamp column to the image
  always_comb begin
    if (virt_col < 0)
      col_sel = '0;
    else if (virt_col >= $signed(VCW'(w_eff)))
      col_sel = CW'(w_eff - 1'b1);
    else
      col_sel = virt_col[CW-1:0];
  end

  assign addr_sum = {1'b0, base} + (AW+1)'(col_sel);
  assign rd_addr  = (addr_sum >= (AW+1)'(DEPTH)) ? AW'(addr_sum - (AW+1)'(DEPTH))
                                                 : addr_sum[AW-1:0];
  assign base_dn  = ({1'b0, base} >= (AW+1)'(w_eff))
                    ? {1'b0, base} - (AW+1)'(w_eff)
                    : {1'b0, base} + (AW+1)'(DEPTH) - (AW+1)'(w_eff);
  assign base_up  = {1'b0, base} + (AW+1)'(w_eff);
  assign orow_up  = {1'b0, orow_base} + (AW+1)'(w_eff);
  assign rd_en    = (state == S_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      width_r  <= 11'd1024;
      height_r <= 13'd768;
      radius_r <= 3'd1;
      in_lin   <= '0;
      wr_addr  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_lin  <= '0;
      orow_base <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      // the emit step reloads the output register itself
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end

      if (rd_vld) begin
        for (int c = 0; c < NC; c++) begin
          sums[c] <= sums[c] + SW'(rd_data[c*CH +: CH]);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (cfg_acc) begin
            unique case (cfg_index)
              bbce_pkg::CFG_WIDTH:  width_r  <= cfg_data[10:0];
              bbce_pkg::CFG_HEIGHT: height_r <= cfg_data;
              bbce_pkg::CFG_RADIUS: radius_r <= cfg_data[2:0];
              default: ;
            endcase
            if (cfg_index == bbce_pkg::CFG_WIDTH || cfg_index == bbce_pkg::CFG_HEIGHT ||
                cfg_index == bbce_pkg::CFG_RADIUS) begin
              in_lin    <= '0;
              wr_addr   <= '0;
              out_col   <= '0;
              out_row   <= '0;
              out_lin   <= '0;
              orow_base <= '0;
            end
          end else if (s_acc) begin
            if (store) begin
              in_lin  <= in_lin + 1'b1;
              wr_addr <= (wr_addr == AW'(DEPTH - 1)) ? '0 : wr_addr + 1'b1;
            end
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (emit_ok) begin
            base     <= orow_base;
            up_cnt   <= up_v;
            cur_row  <= out_row - RWID'(up_v);
            virt_row <= $signed(VRW'(out_row)) - $signed(VRW'(r_eff));
            virt_col <= $signed(VCW'(out_col)) - $signed(VCW'(r_eff));
            dx       <= '0;
            dy       <= '0;
            sums     <= '0;
            state    <= (up_v != '0) ? S_ROWUP : S_READ;
          end else begin
            state <= S_IDLE;
          end
        end

        S_ROWUP: begin
          base   <= base_dn[AW-1:0];
          up_cnt <= up_cnt - 1'b1;
          if (up_cnt == RDW'(1)) begin
            state <= S_READ;
          end
        end

        S_READ: begin
          if (dx == two_r) begin
            dx       <= '0;
            virt_col <= $signed(VCW'(out_col)) - $signed(VCW'(r_eff));
            if (dy == two_r) begin
              state <= S_DRAIN;
            end else begin
              dy       <= dy + 1'b1;
              virt_row <= virt_row + 1'b1;
              if (virt_row >= 0 && (HW'(cur_row) + HW'(1)) < h_eff) begin
                cur_row <= cur_row + 1'b1;
                base    <= (base_up >= (AW+1)'(DEPTH)) ? AW'(base_up - (AW+1)'(DEPTH))
                                                       : base_up[AW-1:0];
              end
            end
          end else begin
            dx       <= dx + 1'b1;
            virt_col <= virt_col + 1'b1;
          end
        end

        S_DRAIN: state <= S_DIVGO;

        S_DIVGO: state <= S_DIVWAIT;

        S_DIVWAIT: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, row_w[11:0], col_w[9:0], quot[2], quot[1], quot[0]};
            m_tlast  <= is_last;
            if (is_last) begin
              in_lin    <= '0;
              wr_addr   <= '0;
              out_col   <= '0;
              out_row   <= '0;
              out_lin   <= '0;
              orow_base <= '0;
            end else begin
              out_lin <= out_lin + 1'b1;
              if (WW'(out_col) == w_eff - 1'b1) begin
                out_col   <= '0;
                out_row   <= out_row + 1'b1;
                orow_base <= (orow_up >= (AW+1)'(DEPTH)) ? AW'(orow_up - (AW+1)'(DEPTH))
                                                         : orow_up[AW-1:0];
              end else begin
                out_col <= out_col + 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign col_w = 32'(out_col);
  assign row_w = 32'(out_row);

  bbce_line_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (s_acc && !cfg_acc && store),
    .wr_addr(wr_addr),
    .wr_data(s_tdata),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  bbce_divider #(
    .NUM_W(NW),
    .SUM_W(SW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(state == S_DIVGO),
    .n    (n_r),
    .sums (sums),
    .done (div_done),
    .quot (quot)
  );

  // write pointer stays inside the line store
  a_wr_addr_range: assert property (@(posedge clk) disable iff (rst)
    32'(wr_addr) < DEPTH)
    else $error("line store write address out of range");

  // no read may still be in flight when a new transaction is taken
  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !rd_vld)
    else $error("read pending while accepting input");

  // output column always lies inside the current image width
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    WW'(out_col) < w_eff)
    else $error("output column beyond image width");

endmodule
